>>> sv/nsr_pkg.sv
// Shared definitions for the Newton square root block: number format, status codes,
// the control word layout and the microprogram ROM.
// No dependencies; every other file of the block uses this package.
package nsr_pkg;

  // Number format: unsigned fixed point, DATA_WIDTH bits in all, FRAC_BITS of them fraction.
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = DATA_WIDTH + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // One is only representable when the fraction leaves room for an integer bit.
  localparam bit ONE_FITS = FRAC_BITS < DATA_WIDTH;
  localparam logic [DATA_WIDTH-1:0] ONE_VAL = ONE_FITS ? (DATA_WIDTH'(1) << FRAC_BITS) : '0;

  // Configuration registers.
  localparam int ITER_W   = 8;
  localparam int TOL_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET  = 8'd20;
  localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 16'd2;

  typedef enum logic [1:0] {
    ST_CONVERGED    = 2'd0,
    ST_BAD_RADICAND = 2'd1,
    ST_ZERO_LIMIT   = 2'd2,
    ST_NO_CONVERGE  = 2'd3
  } status_e;

  // Datapath action of one microcode step.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_INIT,
    ACT_DIV,
    ACT_AVG,
    ACT_ADVANCE,
    ACT_EMIT
  } act_e;

  // Jump condition of one microcode step; the jump is taken when it holds.
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_START,
    CND_BAD_RADICAND,
    CND_ZERO_LIMIT,
    CND_DIV_BUSY,
    CND_CONVERGED,
    CND_AT_LIMIT
  } cond_e;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Microprogram addresses.
  localparam pc_t PC_IDLE     = 4'd0;
  localparam pc_t PC_CHK_RAD  = 4'd1;
  localparam pc_t PC_CHK_LIM  = 4'd2;
  localparam pc_t PC_DIV_GO   = 4'd3;
  localparam pc_t PC_DIV_WAIT = 4'd4;
  localparam pc_t PC_AVG      = 4'd5;
  localparam pc_t PC_TEST     = 4'd6;
  localparam pc_t PC_ADVANCE  = 4'd7;
  localparam pc_t PC_LOOP     = 4'd8;
  localparam pc_t PC_DONE_OK  = 4'd9;
  localparam pc_t PC_DONE_NC  = 4'd10;
  localparam pc_t PC_ERR_RAD  = 4'd11;
  localparam pc_t PC_ERR_LIM  = 4'd12;

  typedef struct packed {
    act_e    act;
    cond_e   cond;
    pc_t     target;
    status_e status;
  } ctrl_t;

  // Condition flags reported by the datapath.
  typedef struct packed {
    logic start;
    logic bad_radicand;
    logic zero_limit;
    logic div_busy;
    logic converged;
    logic at_limit;
  } flags_t;

  // Microprogram ROM.
  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t w;
    w = '{act: ACT_NONE, cond: CND_ALWAYS, target: PC_IDLE, status: ST_CONVERGED};
    unique case (pc)
      PC_IDLE:     w = '{ACT_LOAD,    CND_NO_START,     PC_IDLE,     ST_CONVERGED};
      PC_CHK_RAD:  w = '{ACT_INIT,    CND_BAD_RADICAND, PC_ERR_RAD,  ST_CONVERGED};
      PC_CHK_LIM:  w = '{ACT_NONE,    CND_ZERO_LIMIT,   PC_ERR_LIM,  ST_CONVERGED};
      PC_DIV_GO:   w = '{ACT_DIV,     CND_NEVER,        PC_IDLE,     ST_CONVERGED};
      PC_DIV_WAIT: w = '{ACT_NONE,    CND_DIV_BUSY,     PC_DIV_WAIT, ST_CONVERGED};
      PC_AVG:      w = '{ACT_AVG,     CND_NEVER,        PC_IDLE,     ST_CONVERGED};
      PC_TEST:     w = '{ACT_NONE,    CND_CONVERGED,    PC_DONE_OK,  ST_CONVERGED};
      PC_ADVANCE:  w = '{ACT_ADVANCE, CND_AT_LIMIT,     PC_DONE_NC,  ST_CONVERGED};
      PC_LOOP:     w = '{ACT_NONE,    CND_ALWAYS,       PC_DIV_GO,   ST_CONVERGED};
      PC_DONE_OK:  w = '{ACT_EMIT,    CND_ALWAYS,       PC_IDLE,     ST_CONVERGED};
      PC_DONE_NC:  w = '{ACT_EMIT,    CND_ALWAYS,       PC_IDLE,     ST_NO_CONVERGE};
      PC_ERR_RAD:  w = '{ACT_EMIT,    CND_ALWAYS,       PC_IDLE,     ST_BAD_RADICAND};
      PC_ERR_LIM:  w = '{ACT_EMIT,    CND_ALWAYS,       PC_IDLE,     ST_ZERO_LIMIT};
      default:     w = '{ACT_NONE,    CND_ALWAYS,       PC_IDLE,     ST_CONVERGED};
    endcase
    return w;
  endfunction

endpackage

>>> sv/nsr_divider.sv
// Bit-serial restoring divider: (num << FRAC_BITS) / den, saturated to DATA_WIDTH bits.
// Depends on nsr_pkg for the number format.
module nsr_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [nsr_pkg::DATA_WIDTH-1:0]   num_i,
  input  logic [nsr_pkg::DATA_WIDTH-1:0]   den_i,
  output logic                             busy_o,
  output logic [nsr_pkg::DATA_WIDTH-1:0]   quot_o
);

  localparam int DW = nsr_pkg::DATA_WIDTH;

  logic [nsr_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] quo_q, quo_d;
  logic          sat_q, sat_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  // One restoring step: bring in the next dividend bit, then try the subtraction.
  // After the integer bits run out the shift line feeds zeros for the fraction.
  always_comb begin
    rem_sh  = {rem_q, num_q[DW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
  end

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    num_d = num_q;
    den_d = den_q;
    quo_d = quo_q;
    sat_d = sat_q;
    if (start_i) begin
      cnt_d = nsr_pkg::DIV_CW'(nsr_pkg::DIV_STEPS);
      rem_d = '0;
      num_d = num_i;
      den_d = den_i;
      quo_d = '0;
      sat_d = 1'b0;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      num_d = {num_q[DW-2:0], 1'b0};
      quo_d = {quo_q[DW-2:0], fits};
      // A bit shifted out of the top means the quotient does not fit.
      sat_d = sat_q | quo_q[DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign busy_o = cnt_q != '0;
  // A zero divisor always sets every quotient bit and so saturates as well.
  assign quot_o = sat_q ? '1 : quo_q;

endmodule

>>> sv/nsr_sequencer.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on nsr_pkg for the control word, the flags and the microprogram.
module nsr_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nsr_pkg::flags_t flags_i,
  output nsr_pkg::ctrl_t  ctrl_o,
  output logic            idle_o
);

  nsr_pkg::pc_t pc_q, pc_d;
  logic         take;

  assign ctrl_o = nsr_pkg::ucode_rom(pc_q);
  assign idle_o = pc_q == nsr_pkg::PC_IDLE;

  // Pick the jump condition of the current step.
  always_comb begin
    unique case (ctrl_o.cond)
      nsr_pkg::CND_NEVER:        take = 1'b0;
      nsr_pkg::CND_ALWAYS:       take = 1'b1;
      nsr_pkg::CND_NO_START:     take = !flags_i.start;
      nsr_pkg::CND_BAD_RADICAND: take = flags_i.bad_radicand;
      nsr_pkg::CND_ZERO_LIMIT:   take = flags_i.zero_limit;
      nsr_pkg::CND_DIV_BUSY:     take = flags_i.div_busy;
      nsr_pkg::CND_CONVERGED:    take = flags_i.converged;
      nsr_pkg::CND_AT_LIMIT:     take = flags_i.at_limit;
      default:                   take = 1'b1;
    endcase
    pc_d = take ? ctrl_o.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= nsr_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> sv/newton_square_root.sv
// Top level of the Newton square root block: datapath, configuration registers,
// sequencer and divider. Depends on nsr_pkg, nsr_sequencer and nsr_divider.
//
// Newton-Raphson square root of an unsigned Q16.16 radicand. A request is taken when
// start_i is high and busy_o is low; exactly one result follows, shown for one cycle
// with done_o high, and the receiver must take it then since the block cannot hold it.
// A radicand not above one or a zero iteration limit is reported without running the divider.
// Otherwise each Newton step runs the bit-serial divider, which forms s / p0 one
// quotient bit per cycle. One request is worked at a time; busy_o drops in the cycle
// the result is shown, so the next request may come at once. Configuration is written
// through cfg_we_i, and the user must do so only while the block is idle; the block
// does not enforce this.
module newton_square_root (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [nsr_pkg::DATA_WIDTH-1:0]  radicand_i,
  input  logic                            cfg_we_i,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nsr_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            done_o,
  output logic [nsr_pkg::DATA_WIDTH-1:0]  root_o,
  output logic [1:0]                      status_o,
  output logic [nsr_pkg::ITER_W-1:0]      steps_used_o
);

  localparam int DW = nsr_pkg::DATA_WIDTH;

  nsr_pkg::ctrl_t  ctrl;
  nsr_pkg::flags_t flags;
  logic            idle;
  logic            div_busy;
  logic [DW-1:0]   quot;

  logic [nsr_pkg::ITER_W-1:0] max_iter_q;
  logic [nsr_pkg::TOL_W-1:0]  tol_q;

  logic [DW-1:0] s_q, s_d;
  logic [DW-1:0] p0_q, p0_d;
  logic [DW-1:0] p_q, p_d;
  logic [nsr_pkg::ITER_W-1:0] n_q, n_d;
  logic [DW-1:0] root_q, root_d;
  nsr_pkg::status_e status_q, status_d;
  logic [nsr_pkg::ITER_W-1:0] steps_q, steps_d;
  logic done_q, done_d;

  logic [DW-1:0] p_start;
  logic [DW-1:0] p_avg;
  logic [DW-1:0] diff;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= nsr_pkg::MAX_ITER_RESET;
      tol_q      <= nsr_pkg::TOLERANCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nsr_pkg::REG_MAX_ITER:  max_iter_q <= cfg_data_i[nsr_pkg::ITER_W-1:0];
        nsr_pkg::REG_TOLERANCE: tol_q      <= cfg_data_i[nsr_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Arithmetic of the datapath. Halved terms keep every sum inside DATA_WIDTH bits.
  always_comb begin
    p_start = (s_q >> 1) + (nsr_pkg::ONE_VAL >> 1);
    p_avg   = (p0_q >> 1) + (quot >> 1) + DW'(p0_q[0] & quot[0]);
    diff    = (p_q >= p0_q) ? (p_q - p0_q) : (p0_q - p_q);
  end

  // Condition flags for the sequencer.
  always_comb begin
    flags.start        = start_i;
    flags.bad_radicand = !nsr_pkg::ONE_FITS || (s_q <= nsr_pkg::ONE_VAL);
    flags.zero_limit   = max_iter_q == '0;
    flags.div_busy     = div_busy;
    flags.converged    = diff < DW'(tol_q);
    flags.at_limit     = n_q == max_iter_q;
  end

  // Register updates driven by the current control word.
  always_comb begin
    s_d      = s_q;
    p0_d     = p0_q;
    p_d      = p_q;
    n_d      = n_q;
    root_d   = root_q;
    status_d = status_q;
    steps_d  = steps_q;
    done_d   = 1'b0;
    unique case (ctrl.act)
      nsr_pkg::ACT_NONE: ;
      nsr_pkg::ACT_LOAD: s_d = radicand_i;
      nsr_pkg::ACT_INIT: begin
        p0_d = p_start;
        n_d  = '0;
      end
      nsr_pkg::ACT_DIV:     n_d  = n_q + 1'b1;
      nsr_pkg::ACT_AVG:     p_d  = p_avg;
      nsr_pkg::ACT_ADVANCE: p0_d = p_q;
      nsr_pkg::ACT_EMIT: begin
        done_d   = 1'b1;
        status_d = ctrl.status;
        unique case (ctrl.status)
          nsr_pkg::ST_CONVERGED: begin
            root_d  = p_q;
            steps_d = n_q;
          end
          nsr_pkg::ST_NO_CONVERGE: begin
            root_d  = '0;
            steps_d = max_iter_q;
          end
          default: begin
            root_d  = '0;
            steps_d = '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    p0_q     <= p0_d;
    p_q      <= p_d;
    n_q      <= n_d;
    root_q   <= root_d;
    status_q <= status_d;
    steps_q  <= steps_d;
  end

  nsr_sequencer u_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .idle_o  (idle)
  );

  nsr_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.act == nsr_pkg::ACT_DIV),
    .num_i   (s_q),
    .den_i   (p0_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign busy_o       = !idle;
  assign done_o       = done_q;
  assign root_o       = root_q;
  assign status_o     = status_q;
  assign steps_used_o = steps_q;

endmodule
